[rtl/core/sob_pkg.sv]
// package for the synchronization object bank: command, status and kind codes
// plus field widths shared by the lane and top modules; no dependencies
`timescale 1ns / 1ps
package sob_pkg;
    localparam int SlotCountDefault = 64;
    localparam int MaxWaitDefault = 4;
    localparam int ListLen = 4;

    typedef enum logic [3:0] {
        MODE_NEWSEM = 4'd0, MODE_NEWMUTEX = 4'd1, MODE_NEWEVENT = 4'd2,
        MODE_SEMREL = 4'd3, MODE_MUTEXUNL = 4'd4, MODE_EVSET = 4'd5,
        MODE_EVRESET = 4'd6, MODE_READ = 4'd7, MODE_TRYANY = 4'd8, MODE_FREE = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_INVAL = 3'd1, ST_OVERFLOW = 3'd2, ST_PERM = 3'd3,
        ST_BADSLOT = 3'd4, ST_NONE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_SEM = 2'd0, KIND_MUTEX = 2'd1, KIND_EVENT = 2'd2
    } kind_t;

    // one slot entry as stored in the table memory
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] count;
        logic [31:0] lim_own;
        logic        manual;
        logic        signaled;
    } entry_t;

    // what one lane reports back for its listed slot
    typedef struct packed {
        logic   take;
        entry_t upd;
    } lane_res_t;
endpackage

[rtl/core/sync_object_bank_unit.sv]
// top level of the synchronization object bank: slot table memory, sequencer,
// try-acquire lanes and merge; uses sob_pkg and sob_lane
`timescale 1ns / 1ps
// sequence: S_READ (repeated once per listed slot for try-any, one memory read each),
//   then S_EXEC and S_DONE, after which the result is presented
// issue: one command at a time; the next input transfer is taken only in S_IDLE
//   after the result transfer; the single read port of the slot table makes try-any
//   read its listed slots one after another
// reset: synchronous active-low aresetn clears all valid bits and control state
module sync_object_bank_unit #(
    parameter int SLOT_COUNT = sob_pkg::SlotCountDefault,
    parameter int MAX_WAIT   = sob_pkg::MaxWaitDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] mode, [9:4] slot, [41:10] value_a, [73:42] value_b, [76:74] wait_count,
    // [82:77] wait_slot0, [88:83] wait_slot1, [94:89] wait_slot2, [100:95] wait_slot3
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [34:3] prev_value, [36:35] read_kind, [68:37] read_first,
    // [100:69] read_second, [102:101] acquired_index
    output logic [103:0] m_tdata
);
    import sob_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_LIST, S_DONE
    } fsm_t;

    fsm_t state_reg, state_next;

    // command registers
    logic [3:0]  mode_reg;
    logic [5:0]  slot_reg;
    logic [31:0] a_reg, b_reg;
    logic [2:0]  wc_reg;
    logic [5:0]  list_reg [ListLen];
    logic [2:0]  pos_reg, pos_next;

    // slot table
    entry_t      mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    entry_t      rd_reg;
    entry_t      list_ent_reg [ListLen];
    entry_t      lane_ent [ListLen];
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    entry_t      wr_data;

    logic [103:0] out_reg;
    logic         out_valid_reg;

    logic [5:0] cur_slot;
    logic       in_live, list_ok, list_too_long;
    logic [ListLen-1:0] lane_live, lane_take;
    lane_res_t  lane_res [ListLen];

    logic [2:0]  st;
    logic [31:0] prev, first, second;
    logic [1:0]  kind, idx;
    logic        fire;

    function automatic logic live(input logic [5:0] s,
                                  input logic [SLOT_COUNT-1:0] v);
        logic r;
        r = 1'b0;
        if (32'(s) < SLOT_COUNT) begin
            r = v[s[AW-1:0]];
        end
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // the slot being fetched this cycle
    always_comb begin
        cur_slot = (mode_reg == MODE_TRYANY) ? list_reg[pos_reg[1:0]] : slot_reg;
        rd_addr  = cur_slot[AW-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) state_next = S_READ;
            S_READ: begin
                if (mode_reg == MODE_TRYANY && wc_reg != 3'd0 &&
                    32'(pos_reg) + 1 < 32'(wc_reg) && 32'(wc_reg) <= MAX_WAIT &&
                    wc_reg <= 3'(ListLen)) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // position counter over the wait list
    always_comb begin
        pos_next = pos_reg;
        unique case (state_reg)
            S_IDLE:  pos_next = 3'd0;
            S_READ:  pos_next = pos_reg + 3'd1;
            default: pos_next = pos_reg;
        endcase
    end

    // lanes and merge; the last listed entry is still in the read register
    for (genvar g = 0; g < ListLen; g++) begin : g_lane
        assign lane_ent[g] = (3'(g) + 3'd1 == wc_reg) ? rd_reg : list_ent_reg[g];
        sob_lane u_lane (.entry(lane_ent[g]), .owner(b_reg), .res(lane_res[g]));
        assign lane_live[g] = (3'(g) >= wc_reg) || live(list_reg[g], valid_reg);
        assign lane_take[g] = (3'(g) < wc_reg) && lane_res[g].take;
    end

    assign in_live = live(slot_reg, valid_reg);
    assign list_too_long = (32'(wc_reg) > MAX_WAIT) || (wc_reg > 3'(ListLen));
    assign list_ok = &lane_live;

    // command execution
    always_comb begin
        st = ST_OK; prev = '0; kind = '0; first = '0; second = '0; idx = '0;
        wr_en = 1'b0; wr_addr = slot_reg[AW-1:0]; wr_data = rd_reg;
        fire = (state_reg == S_EXEC);
        unique case (mode_reg)
            MODE_NEWSEM, MODE_NEWMUTEX, MODE_NEWEVENT: begin
                if (mode_reg == MODE_NEWSEM && a_reg > b_reg) st = ST_INVAL;
                else if (32'(slot_reg) >= SLOT_COUNT || in_live) st = ST_BADSLOT;
                else begin
                    wr_en = 1'b1;
                    wr_data.kind = mode_reg[1:0];
                    if (mode_reg == MODE_NEWEVENT) begin
                        wr_data.count = '0; wr_data.lim_own = '0;
                        wr_data.manual = (a_reg != 0); wr_data.signaled = (b_reg != 0);
                    end else begin
                        wr_data.count = a_reg; wr_data.lim_own = b_reg;
                        wr_data.manual = 1'b0; wr_data.signaled = 1'b0;
                    end
                end
            end
            MODE_SEMREL: begin
                if (!in_live) st = ST_BADSLOT;
                else if (rd_reg.kind != KIND_SEM) st = ST_INVAL;
                else if ({1'b0, rd_reg.count} + {1'b0, a_reg} > {1'b0, rd_reg.lim_own})
                    st = ST_OVERFLOW;
                else begin
                    prev = rd_reg.count; wr_en = 1'b1;
                    wr_data.count = rd_reg.count + a_reg;
                end
            end
            MODE_MUTEXUNL: begin
                if (!in_live) st = ST_BADSLOT;
                else if (rd_reg.kind != KIND_MUTEX || b_reg == 0) st = ST_INVAL;
                else if (rd_reg.lim_own != b_reg) st = ST_PERM;
                else begin
                    prev = rd_reg.count; wr_en = 1'b1;
                    wr_data.count = rd_reg.count - 32'd1;
                    if (rd_reg.count == 32'd1) wr_data.lim_own = '0;
                end
            end
            MODE_EVSET, MODE_EVRESET: begin
                if (!in_live) st = ST_BADSLOT;
                else if (rd_reg.kind != KIND_EVENT) st = ST_INVAL;
                else begin
                    prev = {31'd0, rd_reg.signaled}; wr_en = 1'b1;
                    wr_data.signaled = (mode_reg == MODE_EVSET);
                end
            end
            MODE_READ: begin
                if (!in_live) st = ST_BADSLOT;
                else begin
                    kind = rd_reg.kind;
                    if (rd_reg.kind == KIND_EVENT) begin
                        first = {31'd0, rd_reg.manual};
                        second = {31'd0, rd_reg.signaled};
                    end else begin
                        first = rd_reg.count; second = rd_reg.lim_own;
                    end
                end
            end
            MODE_FREE: if (!in_live) st = ST_BADSLOT;
            MODE_TRYANY: begin
                if (list_too_long || !list_ok) st = ST_INVAL;
                else begin
                    st = ST_NONE;
                    for (int i = ListLen - 1; i >= 0; i--) begin
                        if (lane_take[i]) begin
                            st = ST_OK; idx = 2'(i);
                            wr_en = 1'b1;
                            wr_addr = list_reg[i][AW-1:0];
                            wr_data = lane_res[i].upd;
                        end
                    end
                end
            end
            default: st = ST_INVAL;
        endcase
        wr_en = wr_en && fire;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg <= '0;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            if (state_reg == S_DONE) out_valid_reg <= 1'b1;
            if (fire && st == ST_OK) begin
                if (mode_reg == MODE_FREE) valid_reg[slot_reg[AW-1:0]] <= 1'b0;
                else if (mode_reg == MODE_NEWSEM || mode_reg == MODE_NEWMUTEX ||
                         mode_reg == MODE_NEWEVENT)
                    valid_reg[slot_reg[AW-1:0]] <= 1'b1;
            end
        end
    end

    // command capture, table memory and result register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg <= s_tdata[3:0];
            slot_reg <= s_tdata[9:4];
            a_reg <= s_tdata[41:10];
            b_reg <= s_tdata[73:42];
            wc_reg <= s_tdata[76:74];
            list_reg[0] <= s_tdata[82:77];
            list_reg[1] <= s_tdata[88:83];
            list_reg[2] <= s_tdata[94:89];
            list_reg[3] <= s_tdata[100:95];
        end
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
        if (state_reg == S_READ || state_reg == S_EXEC) begin
            if (mode_reg == MODE_TRYANY && pos_reg != 3'd0 &&
                32'(pos_reg) <= ListLen)
                list_ent_reg[2'(pos_reg - 3'd1)] <= rd_reg;
        end
        if (fire) begin
            out_reg <= {1'b0, idx, second, first, kind, prev, st};
        end
    end

    // a result is never presented while a command is still in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == S_IDLE) else $error("result during command");
    // no transfer accepted while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    // a successful free leaves the slot empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && mode_reg == MODE_FREE && st == ST_OK) |=>
        !valid_reg[$past(slot_reg[AW-1:0])]) else $error("free failed");
endmodule

[rtl/core/sob_lane.sv]
// one try-acquire lane: decides whether a slot entry is signaled for an owner
// and forms the entry after acquisition; uses sob_pkg
`timescale 1ns / 1ps
module sob_lane (
    input  sob_pkg::entry_t    entry,
    input  logic [31:0]        owner,
    output sob_pkg::lane_res_t res
);
    import sob_pkg::*;

    // acquire test and updated entry per slot kind
    always_comb begin
        res.take = 1'b0;
        res.upd  = entry;
        unique case (entry.kind)
            KIND_SEM: begin
                res.take = (entry.count != 32'd0);
                res.upd.count = entry.count - 32'd1;
            end
            KIND_MUTEX: begin
                res.take = (entry.lim_own == 32'd0 || entry.lim_own == owner) &&
                           (entry.count != 32'hFFFF_FFFF);
                res.upd.count = entry.count + 32'd1;
                res.upd.lim_own = owner;
            end
            KIND_EVENT: begin
                res.take = entry.signaled;
                if (!entry.manual) begin
                    res.upd.signaled = 1'b0;
                end
            end
            default: begin
                res.take = 1'b0;
            end
        endcase
    end
endmodule
